// File: hw/rtl/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants for the inverted Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

  localparam int PIX_W        = 8;     // grey pixel
  localparam int SUM_W        = 10;    // one weighted kernel column/row sum
  localparam int MAG_W        = 11;    // |Gx| + |Gy|
  localparam int ROW_W        = 12;    // row counter
  localparam int IMG_W_W      = 11;    // image_width register
  localparam int IMG_H_W      = 13;    // image_height register
  localparam int CFG_DATA_W   = 13;    // widest register
  localparam int CFG_IDX_W    = 1;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int PIX_MAX      = 255;

  localparam int OUT_DEPTH    = 4;
  localparam int OUT_PTR_W    = 2;
  localparam int OUT_CNT_W    = 3;

  localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [IMG_H_W-1:0] HEIGHT_RESET = 13'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] edge_value;
    logic             line_end;
    logic             frame_end;
  } out_item_t;

  // Per-item control that rides along the pipeline.
  typedef struct packed {
    logic valid;
    logic emit;
    logic last_col;
    logic last_row;
  } stage_tag_t;

endpackage

// File: hw/rtl/sem_stream_if.sv
// ----------------------------------------------------------------------------
// sem_stream_if
// Valid/ready stream channel with a typed payload.
// ----------------------------------------------------------------------------
interface sem_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/sem_line_store.sv
// ----------------------------------------------------------------------------
// sem_line_store
// Two line memories (upper, middle) with read-modify-write per pixel,
// forwarding for back-to-back hits on one entry, and a clear sweep after reset.
// ----------------------------------------------------------------------------
module sem_line_store
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  input  logic [PIX_W-1:0] rd_px,
  output logic             clearing,
  output logic [PIX_W-1:0] top_px,
  output logic [PIX_W-1:0] mid_px,
  output logic [PIX_W-1:0] cur_px
);

  logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

  logic             clr_busy_r;
  logic [AW-1:0]    clr_addr_r;
  logic             rmw_r;
  logic [AW-1:0]    addr_q_r;
  logic [PIX_W-1:0] px_q_r;
  logic [PIX_W-1:0] rd_upper_r;
  logic [PIX_W-1:0] rd_middle_r;
  logic             fwd_hit_r;
  logic [PIX_W-1:0] fwd_upper_r;
  logic [PIX_W-1:0] fwd_middle_r;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [PIX_W-1:0] wr_upper;
  logic [PIX_W-1:0] wr_middle;

  // read data, or what the previous item wrote to the same entry
  assign top_px   = fwd_hit_r ? fwd_upper_r  : rd_upper_r;
  assign mid_px   = fwd_hit_r ? fwd_middle_r : rd_middle_r;
  assign cur_px   = px_q_r;
  assign clearing = clr_busy_r;

  // middle line moves up, the new pixel becomes the middle line
  assign wr_en     = clr_busy_r | rmw_r;
  assign wr_addr   = clr_busy_r ? clr_addr_r : addr_q_r;
  assign wr_upper  = clr_busy_r ? '0 : mid_px;
  assign wr_middle = clr_busy_r ? '0 : px_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= wr_upper;
      middle_mem[wr_addr] <= wr_middle;
    end
    if (rd_en) begin
      rd_upper_r   <= upper_mem[rd_addr];
      rd_middle_r  <= middle_mem[rd_addr];
      addr_q_r     <= rd_addr;
      px_q_r       <= rd_px;
      fwd_hit_r    <= rmw_r && (addr_q_r == rd_addr);
      fwd_upper_r  <= wr_upper;
      fwd_middle_r <= wr_middle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rmw_r      <= 1'b0;
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      rmw_r <= rd_en;
      if (clr_busy_r) begin
        if (clr_addr_r == AW'(MAX_WIDTH - 1)) begin
          clr_busy_r <= 1'b0;
        end else begin
          clr_addr_r <= clr_addr_r + 1'b1;
        end
      end
    end
  end

  a_no_read_while_clearing: assert property (
    @(posedge clk) disable iff (!rst_n) clr_busy_r |-> !rd_en
  ) else $error("line store read during clear sweep");

endmodule

// File: hw/rtl/sem_kernel.sv
// ----------------------------------------------------------------------------
// sem_kernel
// Six-cell window and the two-stage Sobel gradient, clip and invert.
// ----------------------------------------------------------------------------
module sem_kernel
  import sem_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  stage_tag_t       s1_tag,
  input  logic [PIX_W-1:0] top_px,
  input  logic [PIX_W-1:0] mid_px,
  input  logic [PIX_W-1:0] cur_px,
  output logic             s2_busy,
  output logic             push,
  output out_item_t        push_item
);

  // cells 0..2: column-2 (top, mid, bottom); cells 3..5: column-1
  logic [PIX_W-1:0] win_r [6];

  stage_tag_t       s2_tag_r;
  logic [SUM_W-1:0] pos_x_r, neg_x_r, pos_y_r, neg_y_r;

  logic [SUM_W-1:0] pos_x_nxt, neg_x_nxt, pos_y_nxt, neg_y_nxt;
  logic [SUM_W-1:0] gx, gy;
  logic [MAG_W-1:0] mag;

  // a b c / d . e / f g h  with c=top, e=mid, h=cur
  always_comb begin
    pos_x_nxt = SUM_W'(top_px) + (SUM_W'(mid_px) << 1) + SUM_W'(cur_px);
    neg_x_nxt = SUM_W'(win_r[0]) + (SUM_W'(win_r[1]) << 1) + SUM_W'(win_r[2]);
    pos_y_nxt = SUM_W'(win_r[2]) + (SUM_W'(win_r[5]) << 1) + SUM_W'(cur_px);
    neg_y_nxt = SUM_W'(win_r[0]) + (SUM_W'(win_r[3]) << 1) + SUM_W'(top_px);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
      s2_tag_r <= '0;
    end else begin
      s2_tag_r <= s1_tag;
      if (s1_tag.valid) begin
        win_r[0] <= win_r[3];
        win_r[1] <= win_r[4];
        win_r[2] <= win_r[5];
        win_r[3] <= top_px;
        win_r[4] <= mid_px;
        win_r[5] <= cur_px;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_x_r <= pos_x_nxt;
    neg_x_r <= neg_x_nxt;
    pos_y_r <= pos_y_nxt;
    neg_y_r <= neg_y_nxt;
  end

  always_comb begin
    gx  = (pos_x_r >= neg_x_r) ? (pos_x_r - neg_x_r) : (neg_x_r - pos_x_r);
    gy  = (pos_y_r >= neg_y_r) ? (pos_y_r - neg_y_r) : (neg_y_r - pos_y_r);
    mag = MAG_W'(gx) + MAG_W'(gy);
    push_item.edge_value = (mag > MAG_W'(PIX_MAX)) ? '0
                         : PIX_W'(MAG_W'(PIX_MAX) - mag);
    push_item.line_end   = s2_tag_r.last_col;
    push_item.frame_end  = s2_tag_r.last_col & s2_tag_r.last_row;
  end

  assign push    = s2_tag_r.valid & s2_tag_r.emit;
  assign s2_busy = s2_tag_r.valid;

  a_stage_advance: assert property (
    @(posedge clk) disable iff (!rst_n) s1_tag.valid |=> s2_tag_r.valid
  ) else $error("kernel stage dropped an item");

endmodule

// File: hw/rtl/sem_out_fifo.sv
// ----------------------------------------------------------------------------
// sem_out_fifo
// Small result queue that decouples the pipeline from output stalls.
// ----------------------------------------------------------------------------
module sem_out_fifo
  import sem_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  out_item_t            push_item,
  input  logic                 pop_ready,
  output logic                 pop_valid,
  output out_item_t            pop_item,
  output logic [OUT_CNT_W-1:0] count
);

  out_item_t              slot_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [OUT_CNT_W-1:0]   count_r;
  logic                   pop;

  assign pop_valid = (count_r != '0);
  assign pop_item  = slot_r[rd_ptr_r];
  assign pop       = pop_valid & pop_ready;
  assign count     = count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  a_no_overflow: assert property (
    @(posedge clk) disable iff (!rst_n)
      push |-> (count_r < OUT_CNT_W'(OUT_DEPTH)) || pop
  ) else $error("result queue overflow");

endmodule

// File: hw/rtl/sobel_edge_magnitude_inverted.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_inverted
// Streaming 3x3 Sobel edge map, |Gx|+|Gy| clipped and inverted (255 - sum).
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+------------------------------------
//  in_ch    | in  | valid/ready        | pixel[7:0], frame_start
//  out_ch   | out | valid/ready        | edge_value[7:0], line_end, frame_end
//  cfg_*    | in  | cfg_we, no ready   | cfg_index (0 width, 1 height), data
//
//  One pixel per clock while in_ch.ready is high. After its pixel is taken,
//  a result passes the line memory read register, the gradient sum
//  registers and then the 4-entry result queue on its way to out_ch.
//  After reset a clear sweep zeroes every entry of both line memories,
//  with in_ch.ready low; config writes are taken throughout.
//  Output stalls back up into the queue; in_ch.ready drops once queued plus
//  in-flight items would fill it, so nothing in the pipeline ever waits.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_inverted
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  sem_stream_if.sink            in_ch,
  sem_stream_if.source          out_ch
);

  localparam int AW   = $clog2(MAX_WIDTH);
  // compare width that holds both the column and the width register
  localparam int CMPW = (AW + 1 > IMG_W_W) ? AW + 1 : IMG_W_W;

  // configuration
  logic [IMG_W_W-1:0] img_width_r;
  logic [IMG_H_W-1:0] img_height_r;

  // raster position of the next pixel
  logic [AW-1:0]      col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;

  stage_tag_t         s1_tag_r, s1_tag_nxt;

  logic               accept;
  logic               clearing;
  logic [AW-1:0]      col_cur;
  logic [ROW_W-1:0]   row_cur;
  logic [CMPW-1:0]    width_ext;
  logic [CMPW-1:0]    width_m1;
  logic [ROW_W-1:0]   height_m1;
  logic               last_col, last_row, emit;

  logic [PIX_W-1:0]   top_px, mid_px, cur_px;
  logic               s2_busy;
  logic               push;
  out_item_t          push_item;
  logic [OUT_CNT_W-1:0] q_count;
  logic [OUT_CNT_W-1:0] q_load;
  in_item_t           in_item;
  out_item_t          out_item;

  assign in_item = in_ch.payload;

  // --- config registers -----------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_width_r  <= WIDTH_RESET;
      img_height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:  img_width_r  <= cfg_wdata[IMG_W_W-1:0];
        CFG_IMAGE_HEIGHT: img_height_r <= cfg_wdata[IMG_H_W-1:0];
        default:          img_width_r  <= img_width_r;
      endcase
    end
  end

  // --- input flow control ---------------------------------------------------
  // queued results plus items still in the two pipeline stages must leave
  // room for the one being taken now
  assign q_load = q_count + OUT_CNT_W'(s1_tag_r.valid) + OUT_CNT_W'(s2_busy);
  assign in_ch.ready = !clearing && (q_load < OUT_CNT_W'(OUT_DEPTH));
  assign accept      = in_ch.valid & in_ch.ready;

  // --- effective frame size, saturated -------------------------------------
  assign width_ext = CMPW'(img_width_r);

  always_comb begin
    if (width_ext < CMPW'(3)) begin
      width_m1 = CMPW'(2);
    end else if (width_ext > CMPW'(MAX_WIDTH)) begin
      width_m1 = CMPW'(MAX_WIDTH - 1);
    end else begin
      width_m1 = width_ext - 1'b1;
    end

    if (img_height_r < IMG_H_W'(3)) begin
      height_m1 = ROW_W'(2);
    end else if (img_height_r > IMG_H_W'(HEIGHT_LIMIT)) begin
      height_m1 = ROW_W'(HEIGHT_LIMIT - 1);
    end else begin
      height_m1 = ROW_W'(img_height_r - 1'b1);
    end
  end

  // --- raster counters ------------------------------------------------------
  // frame_start restarts the position before this pixel is placed
  always_comb begin
    col_cur  = in_item.frame_start ? '0 : col_r;
    row_cur  = in_item.frame_start ? '0 : row_r;
    last_col = (CMPW'(col_cur) >= width_m1);
    last_row = (row_cur >= height_m1);
    emit     = (col_cur >= AW'(2)) && (row_cur >= ROW_W'(2));

    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_cur + 1'b1;
      end else begin
        col_nxt = col_cur + 1'b1;
        row_nxt = row_cur;
      end
    end

    s1_tag_nxt.valid    = accept;
    s1_tag_nxt.emit     = emit;
    s1_tag_nxt.last_col = last_col;
    s1_tag_nxt.last_row = last_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      s1_tag_r <= '0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      s1_tag_r <= s1_tag_nxt;
    end
  end

  // --- line memories: read at accept, write back in the following cycle ------
  sem_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_addr  (col_cur),
    .rd_px    (in_item.pixel),
    .clearing (clearing),
    .top_px   (top_px),
    .mid_px   (mid_px),
    .cur_px   (cur_px)
  );

  // --- window and gradient --------------------------------------------------
  sem_kernel u_kernel (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_tag    (s1_tag_r),
    .top_px    (top_px),
    .mid_px    (mid_px),
    .cur_px    (cur_px),
    .s2_busy   (s2_busy),
    .push      (push),
    .push_item (push_item)
  );

  // --- result queue ---------------------------------------------------------
  sem_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop_ready (out_ch.ready),
    .pop_valid (out_ch.valid),
    .pop_item  (out_item),
    .count     (q_count)
  );

  assign out_ch.payload = out_item;

  a_frame_end_on_line_end: assert property (
    @(posedge clk) disable iff (!rst_n)
      (out_ch.valid && out_item.frame_end) |-> out_item.line_end
  ) else $error("frame end without line end");

endmodule

// File: verif/sem_checker.sv
// ----------------------------------------------------------------------------
// sem_checker
// Watches the pixel, result and register ports of the inverted Sobel block.
// Keeps its own copy of the line stores, window and counters, works out the
// expected edge item for every accepted pixel that completes a window, and
// compares the results field by field in order.
// ----------------------------------------------------------------------------
module sem_checker
  import sem_pkg::*;
#(
  parameter int LINE_MAX = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_item,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_item,
  output int                    mismatches,
  output int                    pending_results,
  output int                    results_seen,
  output int                    line_ends_seen,
  output int                    frame_ends_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [PIX_W-1:0]   upper_line  [LINE_MAX];
  logic [PIX_W-1:0]   middle_line [LINE_MAX];
  logic [PIX_W-1:0]   win_cells   [6];   // 0..2 two columns back, 3..5 one back
  int unsigned        col_pos;
  int unsigned        row_pos;
  logic [IMG_W_W-1:0] width_reg;
  logic [IMG_H_W-1:0] height_reg;
  out_item_t          expected_edges [$];

  function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int unsigned gap(int unsigned p, int unsigned n);
    return (p >= n) ? (p - n) : (n - p);
  endfunction

  // Takes one pixel into the model; returns 1 when a full window gives a result.
  function automatic bit predict_edge(input in_item_t px_in, output out_item_t res);
    int unsigned w, h, col, slot, top, mid;
    int unsigned a, b, c, d, e, f, g, hh, gx, gy, s;
    bit          last_col, last_row, emit;
    w = clip(width_reg, 3, LINE_MAX);
    h = clip(height_reg, 3, HEIGHT_LIMIT);
    if (px_in.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    col  = col_pos;
    slot = col % LINE_MAX;
    top  = upper_line[slot];
    mid  = middle_line[slot];
    upper_line[slot]  = PIX_W'(mid);
    middle_line[slot] = px_in.pixel;

    // a b c / d . e / f g hh
    a  = win_cells[0];
    d  = win_cells[1];
    f  = win_cells[2];
    b  = win_cells[3];
    g  = win_cells[5];
    c  = top;
    e  = mid;
    hh = px_in.pixel;
    gx = gap(c + 2 * e + hh, a + 2 * d + f);
    gy = gap(f + 2 * g + hh, a + 2 * b + c);
    s  = gx + gy;

    win_cells[0] = win_cells[3];
    win_cells[1] = win_cells[4];
    win_cells[2] = win_cells[5];
    win_cells[3] = PIX_W'(top);
    win_cells[4] = PIX_W'(mid);
    win_cells[5] = px_in.pixel;

    last_col = (col >= w - 1);
    last_row = (row_pos >= h - 1);
    emit     = (col >= 2) && (row_pos >= 2);
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos = col + 1;
    end

    res.edge_value = (s > PIX_MAX) ? '0 : PIX_W'(PIX_MAX - s);
    res.line_end   = last_col;
    res.frame_end  = last_col && last_row;
    return emit;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t res;
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < LINE_MAX; i++) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      for (int i = 0; i < 6; i++) win_cells[i] = '0;
      col_pos    = 0;
      row_pos    = 0;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      expected_edges.delete();
      mismatches      = 0;
      results_seen    = 0;
      line_ends_seen  = 0;
      frame_ends_seen = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_IMAGE_WIDTH:  width_reg  = cfg_wdata[IMG_W_W-1:0];
          CFG_IMAGE_HEIGHT: height_reg = cfg_wdata[IMG_H_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (predict_edge(in_item, res)) expected_edges.push_back(res);
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_item.line_end) line_ends_seen++;
        if (out_item.frame_end) frame_ends_seen++;
        if (expected_edges.size() == 0) begin
          mismatches++;
          $error("edge item with nothing expected: edge_value %0d line_end %0b frame_end %0b",
                 out_item.edge_value, out_item.line_end, out_item.frame_end);
        end else begin
          want = expected_edges.pop_front();
          if (out_item.edge_value !== want.edge_value) begin
            mismatches++;
            $error("edge_value: expected %0d, got %0d", want.edge_value, out_item.edge_value);
          end
          if (out_item.line_end !== want.line_end) begin
            mismatches++;
            $error("line_end: expected %0b, got %0b", want.line_end, out_item.line_end);
          end
          if (out_item.frame_end !== want.frame_end) begin
            mismatches++;
            $error("frame_end: expected %0b, got %0b", want.frame_end, out_item.frame_end);
          end
        end
      end
    end
    pending_results <= expected_edges.size();
  end

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Top of the inverted Sobel edge map testbench. Drives pixel frames of many
// sizes and shapes through the block under random sender gaps and receiver
// stalls, rewrites the size registers between phases, and reports the
// verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb;
  import sem_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W        = 1024;
  localparam int RANDOM_ITEMS = 1000;
  localparam int SETTLE_GAP   = 6;     // pipeline drain plus slack
  localparam int QUIET_LIMIT  = 4000;  // must outlast the quiet clear sweep after reset

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
  typedef enum int {PAT_NOISE, PAT_FLAT, PAT_RAMP, PAT_SOFT, PAT_EXTREME} pat_t;
  typedef enum int {FRAME_CLEAN, FRAME_NO_START, FRAME_CUT, FRAME_NOISY} frame_kind_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sem_stream_if #(.payload_t(in_item_t))  in_ch ();
  sem_stream_if #(.payload_t(out_item_t)) out_ch ();

  int mismatches;
  int pending_results;
  int results_seen;
  int line_ends_seen;
  int frame_ends_seen;

  int in_idle_pct;     // chance the sender holds off before an item
  int out_stall_pct;   // chance the receiver drops ready in a cycle
  int pixels_sent;
  int phases_run;
  int quiet_cycles;

  sobel_edge_magnitude_inverted #(.MAX_WIDTH(MAX_W)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  sem_checker #(.LINE_MAX(MAX_W)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_item         (in_ch.payload),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_item        (out_ch.payload),
    .mismatches      (mismatches),
    .pending_results (pending_results),
    .results_seen    (results_seen),
    .line_ends_seen  (line_ends_seen),
    .frame_ends_seen (frame_ends_seen)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Receiver: one fresh ready decision per cycle, one assignment per step.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  // Watchdog: any stretch with no item moving on either channel is bounded.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin in_idle_pct = 0;  out_stall_pct = 0;  end
      IDLE_SENDER:   begin in_idle_pct = 82; out_stall_pct = 0;  end
      IDLE_RECEIVER: begin in_idle_pct = 0;  out_stall_pct = 82; end
      default:       begin in_idle_pct = 28; out_stall_pct = 28; end
    endcase
  endtask

  // Presents one item and returns right after the edge that takes it.
  // valid stays high on return so back-to-back items need no extra step.
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= in_item_t'{pixel: pix, frame_start: fs};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pixels_sent++;
  endtask

  // Stops sending and waits until every expected result is out. The checker's
  // count is registered, hence the first edge before looking at it. The fixed
  // gap lets pixels that make no result leave the pipe before a register write.
  task automatic settle_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  // Writes both size registers on consecutive edges; the block is idle here.
  task automatic write_sizes(input logic [CFG_DATA_W-1:0] wreg,
                             input logic [CFG_DATA_W-1:0] hreg);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_wdata <= wreg;
    @(posedge clk);
    cfg_index <= CFG_IMAGE_HEIGHT;
    cfg_wdata <= hreg;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    phases_run++;
  endtask

  function automatic logic [PIX_W-1:0] make_pixel(input pat_t style, input int col,
                                                  input int row, input logic [PIX_W-1:0] base);
    case (style)
      PAT_FLAT:    return {base[7:2], 2'($urandom_range(0, 3))};         // near-flat, edge ~255
      PAT_RAMP:    return PIX_W'(base + col * 3 + row * 2);               // constant gradient
      PAT_SOFT:    return PIX_W'({1'b0, base[7:1]} + $urandom_range(0, 40)); // sums around 255
      PAT_EXTREME: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      default:     return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // One frame of w x lines pixels in raster order. The kind decides how
  // frame_start is used; a cut frame stops early so the next one restarts it.
  task automatic send_frame(input int w, input int lines, input pat_t style,
                            input frame_kind_t kind, input bit pause_mid);
    int              total;
    logic            fs;
    logic [PIX_W-1:0] base;
    total = w * lines;
    if (kind == FRAME_CUT) total = $urandom_range(1, total - 1);
    base = PIX_W'($urandom_range(0, 255));
    for (int n = 0; n < total; n++) begin
      case (kind)
        FRAME_NO_START: fs = 1'b0;
        FRAME_NOISY:    fs = (n == 0) || ($urandom_range(0, 15) == 0);
        default:        fs = (n == 0);
      endcase
      // hold the sender mid-frame until the block has handed everything over
      if (pause_mid && n == total / 2) settle_results();
      send_pixel(make_pixel(style, n % w, n / w, base), fs);
    end
  endtask

  // Directed frames: a flat window (edge 255), sum 254 (edge 1), sum 256
  // (clipped to 0), then out-of-range registers with junk above the width
  // field and an early frame start followed by a full-swing checkerboard.
  task automatic run_directed();
    logic [PIX_W-1:0] ramp_frame [15];
    ramp_frame = '{8'd0, 8'd0, 8'd0,
                   8'd0, 8'd0, 8'd0,
                   8'd0, 8'd0, 8'd0,
                   8'd0, 8'd0, 8'd127,
                   8'd0, 8'd0, 8'd1};
    set_idling(IDLE_NONE);
    write_sizes(13'd3, 13'd5);
    for (int n = 0; n < 15; n++) send_pixel(ramp_frame[n], n == 0);
    settle_results();

    // width field reads 1 (saturates to 3), height 0 (saturates to 3)
    write_sizes(13'h1801, 13'd0);
    for (int n = 0; n < 4; n++) send_pixel(8'hFF, n == 0);
    for (int n = 0; n < 9; n++) send_pixel(((n % 3 + n / 3) % 2 != 0) ? 8'hFF : 8'h00, n == 0);
    settle_results();
  endtask

  // Random phases: mostly small frames, some wide, some tall ones cut short.
  task automatic run_random(input int item_budget);
    int                    start;
    int                    phase_no;
    int                    w_eff;
    int                    h_eff;
    int                    lines;
    int                    pick;
    logic [CFG_DATA_W-1:0] wreg;
    logic [CFG_DATA_W-1:0] hreg;
    frame_kind_t           kind;
    start    = pixels_sent;
    phase_no = 0;
    while (pixels_sent - start < item_budget) begin
      case ($urandom_range(0, 9))
        0: begin
          // upper data bits fall outside the 11-bit width field
          wreg  = {2'($urandom_range(0, 3)), 11'($urandom_range(0, 2))};
          w_eff = 3;
        end
        1: begin
          wreg  = CFG_DATA_W'($urandom_range(24, 64));
          w_eff = wreg;
        end
        default: begin
          wreg  = CFG_DATA_W'($urandom_range(3, 12));
          w_eff = wreg;
        end
      endcase
      if (phase_no == 1) begin
        hreg  = 13'd4096;
        h_eff = HEIGHT_LIMIT;
      end else if (phase_no == 2) begin
        hreg  = CFG_DATA_W'($urandom_range(4097, 8191));
        h_eff = HEIGHT_LIMIT;
      end else begin
        case ($urandom_range(0, 9))
          0: begin hreg = CFG_DATA_W'($urandom_range(0, 2)); h_eff = 3; end
          1: begin hreg = CFG_DATA_W'($urandom_range(4097, 8191)); h_eff = HEIGHT_LIMIT; end
          default: begin hreg = CFG_DATA_W'($urandom_range(3, 8)); h_eff = hreg; end
        endcase
      end
      // tall frames are never finished; the next frame_start cuts them
      lines = (h_eff > 16) ? $urandom_range(3, 8) : h_eff;
      if (w_eff > 16) lines = 3;

      write_sizes(wreg, hreg);
      set_idling(idle_mode_t'(phase_no % 4));
      for (int k = $urandom_range(1, 4); k > 0; k--) begin
        pick = $urandom_range(0, 99);
        if (pick < 70)      kind = FRAME_CLEAN;
        else if (pick < 80) kind = FRAME_NO_START;
        else if (pick < 92) kind = FRAME_CUT;
        else                kind = FRAME_NOISY;
        send_frame(w_eff, lines, pat_t'($urandom_range(0, 4)), kind,
                   (phase_no == 0) || ($urandom_range(0, 9) == 0));
      end
      settle_results();
      phase_no++;
    end
  endtask

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    out_ch.ready  = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_IMAGE_WIDTH;
    cfg_wdata     = '0;
    rst_n         = 1'b0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    pixels_sent   = 0;
    phases_run    = 0;
    quiet_cycles  = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // register writes are taken during the line store clear sweep
    run_directed();
    run_random(RANDOM_ITEMS);

    $display("Covered %0d pixels over %0d register settings (width 3..64, height 3..4096).",
             pixels_sent, phases_run);
    $display("Checked %0d edge items: %0d line ends, %0d frame ends.",
             results_seen, line_ends_seen, frame_ends_seen);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
